>>> rtl/core/safenc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safenc_pkg
// Types, byte positions and character codes for the servo command frame
// encoder.
// ----------------------------------------------------------------------------
package safenc_pkg;

  typedef struct packed {
    logic signed [15:0] angle_centideg;
    logic        [15:0] move_time_ms;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       end_of_frame;
  } out_t;

  localparam int POS_W = 5;
  localparam int REM_W = 14;

  typedef logic [POS_W-1:0] pos_t;

  // byte positions within a full frame "{#iiiPppppTtttt!}"
  localparam pos_t POS_OPEN  = 5'd0;
  localparam pos_t POS_HASH  = 5'd1;
  localparam pos_t POS_P     = 5'd5;
  localparam pos_t POS_T     = 5'd10;
  localparam pos_t POS_BANG  = 5'd15;
  localparam pos_t POS_CLOSE = 5'd16;

  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic signed [15:0] ANGLE_MAX  = 16'sd13500;
  localparam logic signed [15:0] ANGLE_MIN  = -16'sd13500;
  localparam logic [15:0]        TIME_MAX   = 16'd9999;
  localparam logic [11:0]        PULSE_MID  = 12'd1500;
  localparam logic [11:0]        PULSE_MIN  = 12'd500;
  localparam logic [11:0]        PULSE_MAX  = 12'd2500;
  localparam logic [15:0]        ROUND_BIAS = 16'd27;
  // floor(x / 54) = (x * RECIP_54) >> RECIP_SH for x below 2^16
  localparam logic [16:0]        RECIP_54   = 17'd77673;
  localparam int                 RECIP_SH   = 22;

  // decimal weight of the digit at a byte position
  function automatic logic [REM_W-1:0] pos_weight(input pos_t pos);
    logic [REM_W-1:0] w;
    w = 14'd1;
    case (pos)
      5'd2:        w = 14'd100;
      5'd3:        w = 14'd10;
      5'd6, 5'd11: w = 14'd1000;
      5'd7, 5'd12: w = 14'd100;
      5'd8, 5'd13: w = 14'd10;
      default:     w = 14'd1;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/servo_angle_ascii_frame_encoder.sv
`timescale 1ns / 1ps
// The first byte of an item passes the item register and then the byte output register.
// Throughput: one byte per cycle while out_stall is low, set by the single byte output register;
// 15 bytes per item, 16 on the first or last joint of a frame, 17 when NUM_JOINTS is 1.
// The next request is taken in the cycle its predecessor's last byte is loaded.
// Reset (rst_n low, synchronous) clears the joint counter and all valid flags.
// ----------------------------------------------------------------------------
// servo_angle_ascii_frame_encoder
// Converts a joint angle and move time into the ASCII command #iiiPppppTtttt!
// with '{' before joint 0 and '}' after the last joint, one byte per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module servo_angle_ascii_frame_encoder
  import safenc_pkg::*;
#(
  parameter int NUM_JOINTS = 6
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int CNT_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  // joint counter
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cnt_first, cnt_last;

  // item register
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] id_r;
  logic [11:0]      pulse_r;
  logic [REM_W-1:0] time_r;
  logic             last_r;
  pos_t             pos_r, pos_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;

  // output register
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;

  // request path
  logic signed [15:0] ang_c;
  logic [13:0]        mag;
  logic [15:0]        num;
  logic [32:0]        prod;
  logic [10:0]        quo;
  logic [11:0]        pulse_raw, pulse_c;
  logic [REM_W-1:0]   time_c;

  // emit path
  logic             out_load, emit, item_done, in_acc;
  pos_t             end_pos;
  logic [REM_W-1:0] weight, sub, wk;
  logic [3:0]       digit;
  logic [7:0]       byte_sel;

  assign cnt_first = (cnt_r == '0);
  assign cnt_last  = (cnt_r == CNT_W'(NUM_JOINTS - 1));

  always_comb begin
    if (in_data.angle_centideg > ANGLE_MAX) begin
      ang_c = ANGLE_MAX;
    end else if (in_data.angle_centideg < ANGLE_MIN) begin
      ang_c = ANGLE_MIN;
    end else begin
      ang_c = in_data.angle_centideg;
    end
    mag       = ang_c[15] ? 14'(-ang_c) : ang_c[13:0];
    num       = {mag, 2'b00} + ROUND_BIAS;
    prod      = 33'(num) * 33'(RECIP_54);
    quo       = prod[RECIP_SH+10:RECIP_SH];
    pulse_raw = ang_c[15] ? (PULSE_MID - 12'(quo)) : (PULSE_MID + 12'(quo));
    if (pulse_raw < PULSE_MIN) begin
      pulse_c = PULSE_MIN;
    end else if (pulse_raw > PULSE_MAX) begin
      pulse_c = PULSE_MAX;
    end else begin
      pulse_c = pulse_raw;
    end
    time_c = (in_data.move_time_ms > TIME_MAX) ? 14'(TIME_MAX) : in_data.move_time_ms[13:0];
  end

  assign out_load  = !out_valid_r || !out_stall;
  assign emit      = busy_r && out_load;
  assign end_pos   = last_r ? POS_CLOSE : POS_BANG;
  assign item_done = emit && (pos_r == end_pos);
  assign in_stall  = busy_r && !item_done;
  assign in_acc    = in_valid && !in_stall;

  // one decimal digit per cycle from the remainder register, unless the output stalls
  always_comb begin
    weight = pos_weight(pos_r);
    digit  = 4'd0;
    sub    = '0;
    for (int k = 1; k <= 9; k++) begin
      wk = weight * REM_W'(k);
      if (rem_r >= wk) begin
        digit = 4'(k);
        sub   = wk;
      end
    end
  end

  always_comb begin
    case (pos_r)
      POS_OPEN:  byte_sel = CH_OPEN;
      POS_HASH:  byte_sel = CH_HASH;
      POS_P:     byte_sel = CH_P;
      POS_T:     byte_sel = CH_T;
      POS_BANG:  byte_sel = CH_BANG;
      POS_CLOSE: byte_sel = CH_CLOSE;
      default:   byte_sel = CH_ZERO + {4'd0, digit};
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    busy_nxt      = busy_r;
    pos_nxt       = pos_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = busy_r;
    end
    if (emit) begin
      pos_nxt = pos_r + 5'd1;
      case (pos_r)
        POS_HASH: rem_nxt = {{(REM_W-CNT_W){1'b0}}, id_r};
        POS_P:    rem_nxt = {2'b00, pulse_r};
        POS_T:    rem_nxt = time_r;
        POS_OPEN, POS_BANG, POS_CLOSE: rem_nxt = rem_r;
        default:  rem_nxt = rem_r - sub;
      endcase
    end
    if (item_done) begin
      busy_nxt = 1'b0;
    end
    if (in_acc) begin
      busy_nxt = 1'b1;
      pos_nxt  = cnt_first ? POS_OPEN : POS_HASH;
      cnt_nxt  = cnt_last ? '0 : cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      pos_r       <= POS_OPEN;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      busy_r      <= busy_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (in_acc) begin
      id_r    <= cnt_r;
      pulse_r <= pulse_c;
      time_r  <= time_c;
      last_r  <= cnt_last;
    end
    if (emit) begin
      out_data_r.out_byte     <= byte_sel;
      out_data_r.last_of_item <= (pos_r == end_pos);
      out_data_r.end_of_frame <= (pos_r == POS_CLOSE);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_stall_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && out_valid_r && out_stall |-> in_stall)
    else $error("request taken while item blocked");

  a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.end_of_frame |-> out_data_r.last_of_item)
    else $error("frame end not marked as last byte");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pos_r <= POS_CLOSE)
    else $error("byte position out of range");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && pos_r != POS_OPEN && pos_r != POS_HASH && pos_r != POS_P &&
    pos_r != POS_T && pos_r != POS_BANG && pos_r != POS_CLOSE |-> rem_r < 10 * weight)
    else $error("remainder exceeds digit weight");

  a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
    item_done && !in_valid |=> !busy_r)
    else $error("item still busy after last byte");
`endif

endmodule
